// ===== hdl/pftc_pkg.sv =====
// Package for the pump and fan thermal controller.
// Holds the payload structs, register indexes and fixed override-word positions.
// It has no dependencies.
package pftc_pkg;

  typedef struct packed {
    logic signed [7:0] temperature;
    logic              temp_valid;
    logic [31:0]       override_bits;
  } pftc_in_t;

  typedef struct packed {
    logic       pump_relay;
    logic [7:0] pump_duty;
    logic       fan_relay;
  } pftc_out_t;

  typedef enum logic [2:0] {
    REG_PUMP_START = 3'd0,
    REG_PUMP_STOP  = 3'd1,
    REG_PUMP_FULL  = 3'd2,
    REG_FAN_START  = 3'd3,
    REG_FAN_STOP   = 3'd4,
    REG_PUMP_OVR   = 3'd5,
    REG_FAN_OVR    = 3'd6
  } pftc_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Fixed fields of the override word.
  localparam int STAGE_LSB   = 21;
  localparam int FAN_CMD_BIT = 18;

  typedef enum logic [1:0] {
    STAGE_OFF   = 2'd0,
    STAGE_ECO   = 2'd1,
    STAGE_BOOST = 2'd2,
    STAGE_SPARE = 2'd3
  } pftc_stage_t;

  localparam logic signed [7:0] RST_PUMP_START = 8'sd30;
  localparam logic signed [7:0] RST_PUMP_STOP  = 8'sd28;
  localparam logic signed [7:0] RST_PUMP_FULL  = 8'sd65;
  localparam logic signed [7:0] RST_FAN_START  = 8'sd45;
  localparam logic signed [7:0] RST_FAN_STOP   = 8'sd40;
  localparam logic [4:0]        RST_PUMP_OVR   = 5'd23;
  localparam logic [4:0]        RST_FAN_OVR    = 5'd17;

endpackage

// ===== hdl/pftc_div.sv =====
// Restoring divider for the pump duty ramp, one quotient bit per cycle.
// Depends on nothing but its parameter; the quotient must fit in DUTY_WIDTH bits.
module pftc_div #(
  parameter int DUTY_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DUTY_WIDTH+7:0] dividend,
  input  logic [7:0]            divisor,
  output logic                  done,
  output logic [DUTY_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DUTY_WIDTH + 1);

  logic [7:0]            rem_r, rem_nxt;
  logic [DUTY_WIDTH-1:0] quo_r, quo_nxt;
  logic [7:0]            dvs_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [8:0]            trial;
  logic [8:0]            diff;
  logic                  fits;

  // The upper bits of the dividend start out below the divisor, so the
  // partial remainder always stays in eight bits.
  always_comb begin
    trial   = {rem_r, quo_r[DUTY_WIDTH-1]};
    fits    = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[7:0] : trial[7:0];
    quo_nxt = {quo_r[DUTY_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DUTY_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DUTY_WIDTH+7:DUTY_WIDTH];
      quo_r <= dividend[DUTY_WIDTH-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/pump_fan_thermal_controller_top.sv =====
// Top level of the pump and fan thermal controller: sequencer, hysteresis state,
// configuration registers and output register. Uses pftc_pkg and pftc_div.
//
//   Channel   Ports                          Direction  Carries
//   input     in_valid/in_ready/in_data      in         temperature, valid flag, override
//   result    out_valid/out_ready/out_data   out        pump relay, pump duty, fan relay
//   config    cfg_we/cfg_index/cfg_wdata     in         threshold and override-bit writes
//
// An item is taken in idle and evaluated in the evaluation state. When the pump
// duty lies on the ramp, the divider then runs its loop and raises its registered
// done flag, and the output state then loads the output register once it is free;
// any other item goes from evaluation straight to the output state. The divider
// loop makes the ramp path the longer one.
// Reset is synchronous and active low; it restores the register defaults and clears
// both relay states. A result that waits on out_ready does not stop the next transfer
// in; the sequencer only holds its own result until the output register is free.
module pump_fan_thermal_controller_top #(
  parameter int DUTY_WIDTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pftc_pkg::pftc_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pftc_pkg::pftc_out_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [pftc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pftc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import pftc_pkg::*;

  localparam int PW = DUTY_WIDTH + 8;
  // Duty levels follow from the full-scale value of the duty counter.
  localparam logic [DUTY_WIDTH-1:0] FULL_DUTY  = {DUTY_WIDTH{1'b1}};
  localparam logic [DUTY_WIDTH-1:0] ECO_DUTY   = DUTY_WIDTH'(((1 << DUTY_WIDTH) - 1) / 5);
  localparam logic [DUTY_WIDTH-1:0] BOOST_DUTY =
    DUTY_WIDTH'((((1 << DUTY_WIDTH) - 1) * 4) / 5);
  localparam logic [DUTY_WIDTH-1:0] RAMP_GAIN  = FULL_DUTY - ECO_DUTY;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [7:0] pump_start_r, pump_stop_r, pump_full_r;
  logic signed [7:0] fan_start_r, fan_stop_r;
  logic [4:0]        pump_ovr_r, fan_ovr_r;

  // Relay hysteresis state kept between items.
  logic pump_on_r, pump_on_nxt;
  logic fan_on_r, fan_on_nxt;

  // Captured item and working result.
  logic signed [7:0]     temp_r;
  logic                  tvalid_r;
  logic [31:0]           ovr_r;
  logic                  prelay_r, prelay_nxt;
  logic                  frelay_r, frelay_nxt;
  logic [DUTY_WIDTH-1:0] duty_r, duty_nxt;

  pftc_out_t out_data_r;
  logic      out_valid_r;

  logic                  need_div;
  logic [8:0]            num_ext, span_ext;
  logic [PW-1:0]         product;
  logic                  div_done;
  logic [DUTY_WIDTH-1:0] div_quo;
  logic                  out_load;
  pftc_stage_t           stage;

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Ramp operands; both are positive and below 256 whenever the ramp is used.
  assign num_ext  = {temp_r[7], temp_r} - {pump_start_r[7], pump_start_r};
  assign span_ext = {pump_full_r[7], pump_full_r} - {pump_start_r[7], pump_start_r};
  assign product  = {{DUTY_WIDTH{1'b0}}, num_ext[7:0]} * {8'b0, RAMP_GAIN};
  assign stage    = pftc_stage_t'(ovr_r[STAGE_LSB +: 2]);

  // Evaluation of one item. Manual overrides leave the relay states alone; an
  // untrustworthy sample drops both relays in automatic mode. The start test
  // wins over the stop test when the thresholds overlap.
  always_comb begin
    pump_on_nxt = pump_on_r;
    fan_on_nxt  = fan_on_r;
    prelay_nxt  = 1'b0;
    frelay_nxt  = 1'b0;
    duty_nxt    = '0;
    need_div    = 1'b0;

    if (ovr_r[pump_ovr_r]) begin
      unique case (stage)
        STAGE_ECO: begin
          prelay_nxt = 1'b1;
          duty_nxt   = ECO_DUTY;
        end
        STAGE_BOOST: begin
          prelay_nxt = 1'b1;
          duty_nxt   = BOOST_DUTY;
        end
        default: begin
          prelay_nxt = 1'b0;
          duty_nxt   = '0;
        end
      endcase
    end else if (!tvalid_r) begin
      pump_on_nxt = 1'b0;
    end else begin
      if (temp_r >= pump_start_r) begin
        pump_on_nxt = 1'b1;
      end else if (temp_r <= pump_stop_r) begin
        pump_on_nxt = 1'b0;
      end
      prelay_nxt = pump_on_nxt;
      priority if (!pump_on_nxt) begin
        duty_nxt = '0;
      end else if (temp_r <= pump_start_r) begin
        duty_nxt = ECO_DUTY;
      end else if (temp_r >= pump_full_r) begin
        duty_nxt = FULL_DUTY;
      end else begin
        need_div = 1'b1;
      end
    end

    if (ovr_r[fan_ovr_r]) begin
      frelay_nxt = ovr_r[FAN_CMD_BIT];
    end else begin
      priority if (!tvalid_r) begin
        fan_on_nxt = 1'b0;
      end else if (temp_r >= fan_start_r) begin
        fan_on_nxt = 1'b1;
      end else if (temp_r <= fan_stop_r) begin
        fan_on_nxt = 1'b0;
      end else begin
        fan_on_nxt = fan_on_r;
      end
      frelay_nxt = fan_on_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = need_div ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  pftc_div #(
    .DUTY_WIDTH(DUTY_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_EVAL) && need_div),
    .dividend (product),
    .divisor  (span_ext[7:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Control state, configuration and relay state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pump_start_r <= RST_PUMP_START;
      pump_stop_r  <= RST_PUMP_STOP;
      pump_full_r  <= RST_PUMP_FULL;
      fan_start_r  <= RST_FAN_START;
      fan_stop_r   <= RST_FAN_STOP;
      pump_ovr_r   <= RST_PUMP_OVR;
      fan_ovr_r    <= RST_FAN_OVR;
      pump_on_r    <= 1'b0;
      fan_on_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (pftc_reg_t'(cfg_index))
          REG_PUMP_START: pump_start_r <= cfg_wdata;
          REG_PUMP_STOP:  pump_stop_r  <= cfg_wdata;
          REG_PUMP_FULL:  pump_full_r  <= cfg_wdata;
          REG_FAN_START:  fan_start_r  <= cfg_wdata;
          REG_FAN_STOP:   fan_stop_r   <= cfg_wdata;
          REG_PUMP_OVR:   pump_ovr_r   <= cfg_wdata[4:0];
          REG_FAN_OVR:    fan_ovr_r    <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (state_r == S_EVAL) begin
        pump_on_r <= pump_on_nxt;
        fan_on_r  <= fan_on_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      temp_r   <= in_data.temperature;
      tvalid_r <= in_data.temp_valid;
      ovr_r    <= in_data.override_bits;
    end
    if (state_r == S_EVAL) begin
      prelay_r <= prelay_nxt;
      frelay_r <= frelay_nxt;
      duty_r   <= duty_nxt;
    end else if ((state_r == S_DIV) && div_done) begin
      duty_r <= ECO_DUTY + div_quo;
    end
    if (out_load) begin
      out_data_r.pump_relay <= prelay_r;
      out_data_r.pump_duty  <= duty_r[7:0];
      out_data_r.fan_relay  <= frelay_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/pftc_checker.sv =====
// Port-level checks for the pump and fan thermal controller, bound to the top level.
// Uses pftc_pkg for the payload types.
module pftc_port_checks (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input pftc_pkg::pftc_in_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input pftc_pkg::pftc_out_t             out_data,
  input logic                            cfg_we,
  input logic [pftc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pftc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import pftc_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A pump relay that is off never carries a duty.
  a_off_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pump_relay |-> out_data.pump_duty == 8'd0)
    else $error("pump duty nonzero with pump relay off");

  // The block is busy in the cycle after a transfer in.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A new result is only produced while the input side is held off.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in work");

endmodule

bind pump_fan_thermal_controller_top pftc_port_checks u_pftc_checker (.*);

// ===== verif/pftc_checker.sv =====
// Checker for the pump and fan thermal controller: mirrors the registers and relay
// states, predicts every result from the input transfers and compares in order.
// Depends on pftc_pkg only.
module pftc_checker
  import pftc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pftc_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pftc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUTY_FULL  = 255;
  localparam int DUTY_ECO   = DUTY_FULL / 5;
  localparam int DUTY_BOOST = (DUTY_FULL * 4) / 5;

  int         pump_start_t;
  int         pump_stop_t;
  int         pump_full_t;
  int         fan_start_t;
  int         fan_stop_t;
  logic [4:0] pump_ovr_sel;
  logic [4:0] fan_ovr_sel;
  logic       pump_latched;
  logic       fan_latched;

  pftc_out_t  pending_drive[$];
  pftc_out_t  want;

  // Works out the drive for one sample and advances the relay states.
  function automatic pftc_out_t next_drive(input pftc_in_t item);
    pftc_out_t   r;
    int          t;
    pftc_stage_t stage;
    r = '0;
    t = $signed(item.temperature);
    if (item.override_bits[pump_ovr_sel]) begin
      stage = pftc_stage_t'(item.override_bits[STAGE_LSB +: 2]);
      case (stage)
        STAGE_ECO: begin
          r.pump_relay = 1'b1;
          r.pump_duty  = 8'(DUTY_ECO);
        end
        STAGE_BOOST: begin
          r.pump_relay = 1'b1;
          r.pump_duty  = 8'(DUTY_BOOST);
        end
        default: ;
      endcase
    end else if (!item.temp_valid) begin
      pump_latched = 1'b0;
    end else begin
      if (t >= pump_start_t) pump_latched = 1'b1;
      else if (t <= pump_stop_t) pump_latched = 1'b0;
      r.pump_relay = pump_latched;
      if (!pump_latched) r.pump_duty = '0;
      else if (t <= pump_start_t) r.pump_duty = 8'(DUTY_ECO);
      else if (t >= pump_full_t) r.pump_duty = 8'(DUTY_FULL);
      else r.pump_duty = 8'(DUTY_ECO + ((t - pump_start_t) * (DUTY_FULL - DUTY_ECO)) /
                                       (pump_full_t - pump_start_t));
    end
    if (item.override_bits[fan_ovr_sel]) begin
      r.fan_relay = item.override_bits[FAN_CMD_BIT];
    end else begin
      if (!item.temp_valid) fan_latched = 1'b0;
      else if (t >= fan_start_t) fan_latched = 1'b1;
      else if (t <= fan_stop_t) fan_latched = 1'b0;
      r.fan_relay = fan_latched;
    end
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pump_start_t = RST_PUMP_START;
      pump_stop_t  = RST_PUMP_STOP;
      pump_full_t  = RST_PUMP_FULL;
      fan_start_t  = RST_FAN_START;
      fan_stop_t   = RST_FAN_STOP;
      pump_ovr_sel = RST_PUMP_OVR;
      fan_ovr_sel  = RST_FAN_OVR;
      pump_latched = 1'b0;
      fan_latched  = 1'b0;
      pending_drive.delete();
    end else begin
      if (cfg_we) begin
        case (pftc_reg_t'(cfg_index))
          REG_PUMP_START: pump_start_t = $signed(cfg_wdata);
          REG_PUMP_STOP:  pump_stop_t  = $signed(cfg_wdata);
          REG_PUMP_FULL:  pump_full_t  = $signed(cfg_wdata);
          REG_FAN_START:  fan_start_t  = $signed(cfg_wdata);
          REG_FAN_STOP:   fan_stop_t   = $signed(cfg_wdata);
          REG_PUMP_OVR:   pump_ovr_sel = cfg_wdata[4:0];
          REG_FAN_OVR:    fan_ovr_sel  = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_drive.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = pending_drive.pop_front();
          if (out_data.pump_relay !== want.pump_relay) begin
            $error("pump_relay: expected %0d, actual %0d", want.pump_relay,
                   out_data.pump_relay);
            fail_count++;
          end
          if (out_data.pump_duty !== want.pump_duty) begin
            $error("pump_duty: expected %0d, actual %0d", want.pump_duty,
                   out_data.pump_duty);
            fail_count++;
          end
          if (out_data.fan_relay !== want.fan_relay) begin
            $error("fan_relay: expected %0d, actual %0d", want.fan_relay,
                   out_data.fan_relay);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) pending_drive.push_back(next_drive(in_data));
    end
    pending_count = pending_drive.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top of the pump and fan thermal controller testbench: clock, reset, samples,
// register settings and verdict. Depends on pftc_pkg, pftc_checker and the block.
module tb;
  import pftc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_SEG = 250;
  localparam int NUM_SEGS      = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pftc_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  pftc_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_count;

  // Idle rates in percent for the two sides of the block.
  int in_idle_pct;
  int out_idle_pct;

  // The stimulus keeps its own view of the thresholds so that random samples can
  // be steered to where the relays actually switch.
  int thr[5];
  int pump_sel;
  int fan_sel;
  int walk_t;

  pump_fan_thermal_controller_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pftc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // A hang anywhere ends the run as a failure.
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // The receiver decides afresh at every falling edge whether it takes a result.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic pftc_in_t sample(input int t, input logic v, input logic [31:0] ovr);
    pftc_in_t s;
    s.temperature   = 8'(t);
    s.temp_valid    = v;
    s.override_bits = ovr;
    return s;
  endfunction

  // One input transfer. The valid is raised at a falling edge, possibly after some
  // idle cycles, and held with its payload until the block takes it. It is left high
  // on return so that back-to-back samples never drop it for a cycle.
  task automatic send_sample(input pftc_in_t s);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Brings the block to rest: no pending transfer and every result back, plus a
  // margin for the sequencer to settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Register write. The enable is lowered at the next falling edge, so two writes
  // in a row never touch it twice in one time step.
  task automatic write_reg(input pftc_reg_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 8'(val);
    case (idx)
      REG_PUMP_START: thr[0] = $signed(8'(val));
      REG_PUMP_STOP:  thr[1] = $signed(8'(val));
      REG_PUMP_FULL:  thr[2] = $signed(8'(val));
      REG_FAN_START:  thr[3] = $signed(8'(val));
      REG_FAN_STOP:   thr[4] = $signed(8'(val));
      REG_PUMP_OVR:   pump_sel = val & 31;
      REG_FAN_OVR:    fan_sel  = val & 31;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes one full setting. Upper bits of the override-bit registers get random
  // junk, which the block must ignore.
  task automatic write_setting(input int ps, input int pp, input int pf, input int fs,
                               input int fp, input int po, input int fo);
    write_reg(REG_PUMP_START, ps);
    write_reg(REG_PUMP_STOP, pp);
    write_reg(REG_PUMP_FULL, pf);
    write_reg(REG_FAN_START, fs);
    write_reg(REG_FAN_STOP, fp);
    write_reg(REG_PUMP_OVR, int'({3'($urandom_range(7)), 5'(po)}));
    write_reg(REG_FAN_OVR, int'({3'($urandom_range(7)), 5'(fo)}));
  endtask

  // Settings per segment: the reset defaults, three corner settings and random ones.
  // The first two have a full temperature that is not above the start temperature,
  // the third the stop threshold above the start threshold and a full one below it.
  task automatic apply_segment(input int seg);
    int base;
    case (seg)
      0: ;
      1: write_setting(127, -128, 127, -128, 127, 0, 31);
      2: write_setting(-128, -128, -128, 127, -128, 31, 0);
      3: write_setting(0, 20, -10, -5, 10, 22, 18);
      default: begin
        base = $urandom_range(0, 200) - 100;
        write_setting(base, base - $urandom_range(0, 8), base + $urandom_range(0, 90) - 5,
                      base + $urandom_range(0, 40) - 20, base + $urandom_range(0, 30) - 25,
                      $urandom_range(31), $urandom_range(31));
      end
    endcase
  endtask

  // Random samples. Most follow a slow walk through the threshold region so the
  // hysteresis is exercised in both directions; some sit at or next to a threshold
  // and the rest are anywhere in range.
  function automatic pftc_in_t random_sample();
    int          lo;
    int          hi;
    int          sel;
    int          t;
    logic [31:0] ovr;
    lo = thr[0];
    hi = thr[0];
    for (int i = 1; i < 5; i++) begin
      if (thr[i] < lo) lo = thr[i];
      if (thr[i] > hi) hi = thr[i];
    end
    lo  = clamp(lo - 8, -128, 127);
    hi  = clamp(hi + 8, -128, 127);
    sel = $urandom_range(99);
    if (sel < 60) begin
      walk_t = clamp(walk_t + $urandom_range(0, 6) - 3, lo, hi);
      t = walk_t;
    end else if (sel < 80) begin
      t = clamp(thr[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1, -128, 127);
    end else begin
      t = $signed(8'($urandom_range(0, 255)));
    end
    ovr = $urandom;
    if ($urandom_range(99) < 70) ovr[pump_sel] = 1'b0;
    if ($urandom_range(99) < 70) ovr[fan_sel] = 1'b0;
    return sample(t, ($urandom_range(99) < 90), ovr);
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_idle_pct  = 20;
    out_idle_pct = 77;
    thr          = '{30, 28, 65, 45, 40};
    pump_sel     = 23;
    fan_sel      = 17;
    walk_t       = 35;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples at the reset setting: the climb through the pump hysteresis
    // band and ramp, the fan band, an untrusted sample, every manual pump stage,
    // both manual fan commands and the all-ones override word.
    send_sample(sample(-128, 1'b1, 32'h0));
    send_sample(sample(30, 1'b1, 32'h0));
    send_sample(sample(29, 1'b1, 32'h0));
    send_sample(sample(28, 1'b1, 32'h0));
    send_sample(sample(29, 1'b1, 32'h0));
    send_sample(sample(31, 1'b1, 32'h0));
    send_sample(sample(64, 1'b1, 32'h0));
    send_sample(sample(65, 1'b1, 32'h0));
    send_sample(sample(127, 1'b1, 32'h0));
    send_sample(sample(41, 1'b1, 32'h0));
    send_sample(sample(40, 1'b1, 32'h0));
    send_sample(sample(127, 1'b0, 32'h0));
    send_sample(sample(127, 1'b1, 32'h0080_0000));
    send_sample(sample(127, 1'b1, 32'h00A0_0000));
    send_sample(sample(127, 1'b1, 32'h00C0_0000));
    send_sample(sample(127, 1'b1, 32'h00E0_0000));
    send_sample(sample(-128, 1'b1, 32'h0006_0000));
    send_sample(sample(127, 1'b1, 32'h0002_0000));
    send_sample(sample(-1, 1'b0, 32'hFFFF_FFFF));
    send_sample(sample(45, 1'b1, 32'h0));
    send_sample(sample(0, 1'b0, 32'h00C0_0000));
    send_sample(sample(44, 1'b1, 32'hFF7D_FFFF));

    // Random segments, each under its own setting. The idle pattern moves from a
    // slow receiver to a slow sender and then to full speed on both sides.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      apply_segment(seg);
      in_idle_pct  = (seg < 2) ? 20 : ((seg < 4) ? 77 : 0);
      out_idle_pct = (seg < 2) ? 77 : ((seg < 4) ? 20 : 0);
      walk_t = thr[0];
      for (int n = 0; n < ITEMS_PER_SEG; n++) send_sample(random_sample());
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
